[src/rwmf_pkg.sv]
// shared widths, codes and control structs of the rgb window median filter
package rwmf_pkg;

   localparam int PIX_W      = 8;
   localparam int POS_W      = 6;
   localparam int CFG_W      = 7;
   localparam int WIN_W      = 3;
   localparam int CNT_W      = 6;
   localparam int BIT_W      = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int RGB_W      = 3 * PIX_W;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE  = 2'd2;

   localparam logic [CFG_W-1:0] RESET_IMAGE_WIDTH  = 7'd64;
   localparam logic [CFG_W-1:0] RESET_IMAGE_HEIGHT = 7'd64;
   localparam logic [WIN_W-1:0] RESET_WINDOW_SIZE  = 3'd3;

   // window walker status: sample and in_frame in the cycle after the address issued,
   // last in the same cycle as the final address
   typedef struct packed {
      logic sample;
      logic in_frame;
      logic last;
   } walk_stat_type;

   // sequencer commands to the rank select lanes
   typedef struct packed {
      logic             start;
      logic             sample;
      logic             pass_end;
      logic             tail;
      logic [BIT_W-1:0] bit_idx;
      logic [CNT_W-1:0] half_n;
   } sel_ctrl_type;

endpackage

[src/rwmf_ram.sv]
// generic simple dual-port ram with registered read
module rwmf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/rwmf_walker.sv]
// window walker: issues one pixel store address per cycle over the window
module rwmf_walker
   import rwmf_pkg::*;
#(
   parameter int MAX_WIDTH = 64,
   parameter int ADDR_W    = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic              start,
   input  logic [POS_W-1:0]  row_in,
   input  logic [POS_W-1:0]  col_in,
   input  logic [WIN_W-1:0]  win_in,
   input  logic [CFG_W-1:0]  lim_w,
   input  logic [CFG_W-1:0]  lim_h,
   output logic [ADDR_W-1:0] rd_addr,
   output walk_stat_type     stat
);

   logic [POS_W-1:0] row_ff, row_in_nx;
   logic [POS_W-1:0] col_ff, col_in_nx;
   logic [WIN_W-1:0] win_ff, win_in_nx;
   logic [WIN_W-1:0] wr_ff, wr_in;
   logic [WIN_W-1:0] wc_ff, wc_in;
   logic             busy_ff, busy_in;
   logic             smp_ff, smp_in;
   logic             inf_ff, inf_in;

   logic [7:0]       r_pos, c_pos;
   logic [7:0]       half;
   logic             pos_ok;
   logic             last_elem;

   // offsets start at -(w/2); bit 7 set means the position fell off the top or left
   assign half  = 8'(win_ff >> 1);
   assign r_pos = {2'b00, row_ff} + {5'b0, wr_ff} - half;
   assign c_pos = {2'b00, col_ff} + {5'b0, wc_ff} - half;
   assign pos_ok = !r_pos[7] && !c_pos[7] && (r_pos[6:0] < lim_h) && (c_pos[6:0] < lim_w);
   assign rd_addr = ADDR_W'(32'(r_pos[6:0]) * MAX_WIDTH + 32'(c_pos[6:0]));

   assign last_elem = busy_ff && (wr_ff == win_ff - 3'd1) && (wc_ff == win_ff - 3'd1);

   always_comb begin
      row_in_nx = row_ff;
      col_in_nx = col_ff;
      win_in_nx = win_ff;
      wr_in     = wr_ff;
      wc_in     = wc_ff;
      busy_in   = busy_ff;
      if (load) begin
         row_in_nx = row_in;
         col_in_nx = col_in;
         win_in_nx = win_in;
      end
      if (start) begin
         wr_in   = '0;
         wc_in   = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (wc_ff == win_ff - 3'd1) begin
            wc_in = '0;
            if (wr_ff == win_ff - 3'd1) begin
               busy_in = 1'b0;
            end else begin
               wr_in = wr_ff + 3'd1;
            end
         end else begin
            wc_in = wc_ff + 3'd1;
         end
      end
      smp_in = busy_ff;
      inf_in = busy_ff && pos_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         smp_ff  <= 1'b0;
         inf_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         smp_ff  <= smp_in;
         inf_ff  <= inf_in;
      end
      row_ff <= row_in_nx;
      col_ff <= col_in_nx;
      win_ff <= win_in_nx;
      wr_ff  <= wr_in;
      wc_ff  <= wc_in;
   end

   assign stat.sample   = smp_ff;
   assign stat.in_frame = inf_ff;
   assign stat.last     = last_elem;

endmodule

[src/rwmf_select.sv]
// rank select lane: finds the k-th smallest value one bit per pass
module rwmf_select
   import rwmf_pkg::*;
(
   input  logic             clock,
   input  sel_ctrl_type     ctrl,
   input  logic [PIX_W-1:0] value,
   output logic [PIX_W-1:0] median
);

   logic [PIX_W-1:0] pfx_ff, pfx_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] lt_cnt_ff, lt_cnt_in;
   logic [PIX_W-1:0] lt_max_ff, lt_max_in;

   logic [8:0]       hi_mask_w;
   logic [PIX_W-1:0] hi_mask;
   logic             match;
   logic [PIX_W-1:0] lower_mid;
   logic [8:0]       mid_sum;

   // bits above the one under test must equal the prefix found so far
   assign hi_mask_w = 9'h1FF << ({1'b0, ctrl.bit_idx} + 4'd1);
   assign hi_mask   = hi_mask_w[PIX_W-1:0];
   assign match     = (((value ^ pfx_ff) & hi_mask) == '0) && !value[ctrl.bit_idx];

   always_comb begin
      pfx_in    = pfx_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      lt_cnt_in = lt_cnt_ff;
      lt_max_in = lt_max_ff;
      if (ctrl.start) begin
         pfx_in    = '0;
         k_in      = ctrl.half_n;
         cnt_in    = '0;
         lt_cnt_in = '0;
         lt_max_in = '0;
      end else if (ctrl.sample) begin
         if (ctrl.tail) begin
            // tail pass: largest value below the upper middle
            if (value < pfx_ff) begin
               lt_cnt_in = lt_cnt_ff + 6'd1;
               if (value > lt_max_ff) begin
                  lt_max_in = value;
               end
            end
         end else if (match) begin
            cnt_in = cnt_ff + 6'd1;
         end
      end else if (ctrl.pass_end && !ctrl.tail) begin
         if (k_ff >= cnt_ff) begin
            pfx_in[ctrl.bit_idx] = 1'b1;
            k_in = k_ff - cnt_ff;
         end
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      pfx_ff    <= pfx_in;
      k_ff      <= k_in;
      cnt_ff    <= cnt_in;
      lt_cnt_ff <= lt_cnt_in;
      lt_max_ff <= lt_max_in;
   end

   assign lower_mid = (lt_cnt_ff >= ctrl.half_n) ? lt_max_ff : pfx_ff;
   assign mid_sum   = {1'b0, lower_mid} + {1'b0, pfx_ff};
   assign median    = ctrl.tail ? mid_sum[8:1] : pfx_ff;

endmodule

[src/rgb_window_median_filter.sv]
// rgb window median filter: pixel store, window walker and rank select sequencer
//
// req channel: tuser[0] = 0 writes the pixel in tdata at (row, col), 1 asks for the
// per-channel median of the window around (row, col). a write gives no response;
// writes may follow each other every cycle.
// rsp channel: one response per median request, tuser flags a position outside the
// configured frame (the channel values are then zero).
// csr channel: always ready, index 0 image width, 1 image height, 2 window size;
// write only while no request is in flight.
// an in-frame request with n = w*w window pixels takes 8 bit passes (plus one more
// pass when n is even), each walking the window, waiting and deciding one bit,
// then a final and an output state. the single read port of the pixel store gives
// one window pixel per cycle to the three rank select lanes. an out-of-frame
// request goes straight to the output state. req_tready is low while
// a request is worked on and while its finished response cannot enter the output
// register because an earlier response there still waits for rsp_tready.
// reset sets width 64, height 64, window 3 and empties the response register;
// the pixel store is not cleared and must be written before it is read.
module rgb_window_median_filter
   import rwmf_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int MAX_WINDOW = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // row[5:0], col[11:6], red_in[19:12], green_in[27:20], blue_in[35:28], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd[0]
   input  logic [0:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // red_out[7:0], green_out[15:8], blue_out[23:16]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // out_of_range[0]
   output logic [0:0]            rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_data
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int W_LIM  = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
   localparam int H_LIM  = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;
   localparam int WN_LIM = (MAX_WINDOW < 7) ? MAX_WINDOW : 7;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WALK   = 3'd1;
   localparam logic [2:0] S_WAIT   = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_FIN    = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   logic [CFG_W-1:0]      width_ff, width_in;
   logic [CFG_W-1:0]      height_ff, height_in;
   logic [WIN_W-1:0]      window_ff, window_in;
   logic [2:0]            state_ff, state_in;
   logic [BIT_W-1:0]      bit_ff, bit_in;
   logic                  tail_ff, tail_in;
   logic [RGB_W-1:0]      res_ff, res_in;
   logic                  res_oor_ff, res_oor_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RGB_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                  rsp_oor_ff, rsp_oor_in;

   logic [CFG_W-1:0]      eff_w, eff_h;
   logic [WIN_W-1:0]      eff_win;
   logic [CNT_W-1:0]      win_n;
   logic [CNT_W-1:0]      half_n;
   logic                  n_even;

   logic                  req_accept;
   logic                  req_cmd;
   logic [POS_W-1:0]      req_row, req_col;
   logic [PIX_W-1:0]      req_red, req_green, req_blue;
   logic                  req_in_frame;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic [RGB_W-1:0]      rd_data;
   logic [RGB_W-1:0]      px;

   logic                  walk_load, walk_start, sel_start;
   walk_stat_type         walk_stat;
   sel_ctrl_type          sel_ctrl;
   logic [PIX_W-1:0]      red_med, green_med, blue_med;

   // register clamps
   assign eff_w = (width_ff == '0) ? CFG_W'(1) :
                  (width_ff > CFG_W'(W_LIM)) ? CFG_W'(W_LIM) : width_ff;
   assign eff_h = (height_ff == '0) ? CFG_W'(1) :
                  (height_ff > CFG_W'(H_LIM)) ? CFG_W'(H_LIM) : height_ff;
   assign eff_win = (window_ff == '0) ? WIN_W'(1) :
                    (window_ff > WIN_W'(WN_LIM)) ? WIN_W'(WN_LIM) : window_ff;
   assign win_n  = {3'b000, eff_win} * {3'b000, eff_win};
   assign half_n = win_n >> 1;
   assign n_even = !win_n[0];

   assign req_cmd   = req_tuser[0];
   assign req_row   = req_tdata[5:0];
   assign req_col   = req_tdata[11:6];
   assign req_red   = req_tdata[19:12];
   assign req_green = req_tdata[27:20];
   assign req_blue  = req_tdata[35:28];

   assign req_tready   = (state_ff == S_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign req_in_frame = ({1'b0, req_row} < eff_h) && ({1'b0, req_col} < eff_w);

   assign wr_en   = req_accept && (req_cmd == CMD_WRITE) && req_in_frame;
   assign wr_addr = ADDR_W'(32'(req_row) * MAX_WIDTH + 32'(req_col));

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      window_in = window_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_data;
            CSR_IMAGE_HEIGHT: height_in = csr_data;
            CSR_WINDOW_SIZE:  window_in = csr_data[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   rwmf_ram #(
      .WIDTH (RGB_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_red, req_green, req_blue}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rwmf_walker #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_W    (ADDR_W)
   ) u_walker (
      .clock   (clock),
      .reset   (reset),
      .load    (walk_load),
      .start   (walk_start),
      .row_in  (req_row),
      .col_in  (req_col),
      .win_in  (eff_win),
      .lim_w   (eff_w),
      .lim_h   (eff_h),
      .rd_addr (rd_addr),
      .stat    (walk_stat)
   );

   // positions outside the frame read as zero
   assign px = walk_stat.in_frame ? rd_data : '0;

   assign sel_ctrl.start    = sel_start;
   assign sel_ctrl.sample   = walk_stat.sample;
   assign sel_ctrl.pass_end = (state_ff == S_DECIDE);
   assign sel_ctrl.tail     = tail_ff;
   assign sel_ctrl.bit_idx  = bit_ff;
   assign sel_ctrl.half_n   = half_n;

   rwmf_select u_sel_red (
      .clock  (clock),
      .ctrl   (sel_ctrl),
      .value  (px[23:16]),
      .median (red_med)
   );

   rwmf_select u_sel_green (
      .clock  (clock),
      .ctrl   (sel_ctrl),
      .value  (px[15:8]),
      .median (green_med)
   );

   rwmf_select u_sel_blue (
      .clock  (clock),
      .ctrl   (sel_ctrl),
      .value  (px[7:0]),
      .median (blue_med)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      bit_in       = bit_ff;
      tail_in      = tail_ff;
      res_in       = res_ff;
      res_oor_in   = res_oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_oor_in   = rsp_oor_ff;
      walk_load    = 1'b0;
      walk_start   = 1'b0;
      sel_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_cmd == CMD_READ)) begin
               if (req_in_frame) begin
                  walk_load  = 1'b1;
                  walk_start = 1'b1;
                  sel_start  = 1'b1;
                  bit_in     = BIT_W'(PIX_W - 1);
                  tail_in    = 1'b0;
                  state_in   = S_WALK;
               end else begin
                  res_in     = '0;
                  res_oor_in = 1'b1;
                  state_in   = S_OUT;
               end
            end
         end
         S_WALK: begin
            if (walk_stat.last) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (tail_ff) begin
               state_in = S_FIN;
            end else if (bit_ff == '0) begin
               if (n_even) begin
                  // extra pass for the lower middle value
                  tail_in    = 1'b1;
                  walk_start = 1'b1;
                  state_in   = S_WALK;
               end else begin
                  state_in = S_FIN;
               end
            end else begin
               bit_in     = bit_ff - 3'd1;
               walk_start = 1'b1;
               state_in   = S_WALK;
            end
         end
         S_FIN: begin
            res_in     = {blue_med, green_med, red_med};
            res_oor_in = 1'b0;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_oor_in   = res_oor_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= RESET_IMAGE_WIDTH;
         height_ff    <= RESET_IMAGE_HEIGHT;
         window_ff    <= RESET_WINDOW_SIZE;
         state_ff     <= S_IDLE;
         tail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         window_ff    <= window_in;
         state_ff     <= state_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bit_ff      <= bit_in;
      res_ff      <= res_in;
      res_oor_ff  <= res_oor_in;
      rsp_data_ff <= rsp_data_in;
      rsp_oor_ff  <= rsp_oor_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_oor_ff;

   a_last_in_walk: assert property (@(posedge clock) disable iff (reset)
      walk_stat.last |-> (state_ff == S_WALK))
      else $error("walker finished outside a walk pass");

   a_no_sample_at_decide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) |-> !walk_stat.sample)
      else $error("window pixel arrived while a bit was being decided");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_OUT))
      else $error("response raised without passing the output state");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_oor_ff) |-> (rsp_data_ff == '0))
      else $error("out-of-frame response carries nonzero pixel data");

endmodule
